[rtl/dual_sonar_trimmed_mean_steer_assert.svh]
// assertion macros shared by the sonar filter rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef DUAL_SONAR_TRIMMED_MEAN_STEER_ASSERT_SVH
`define DUAL_SONAR_TRIMMED_MEAN_STEER_ASSERT_SVH

// condition holds at every edge out of reset
`define DSTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DSTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DSTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dsts_pkg.sv]
// types, constants and small tables of the dual sonar trimmed mean filter
// no dependencies
package dsts_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_VALID_RANGE   = 2'd0;
    localparam logic [1:0] CFG_STOP_DISTANCE = 2'd1;
    localparam logic [1:0] CFG_STEER_MARGIN  = 2'd2;
    localparam logic [1:0] CFG_ALARM_SUM     = 2'd3;

    localparam int unsigned CFG_DATA_W = 17;

    // steering codes
    localparam logic [1:0] STEER_GO    = 2'd0;
    localparam logic [1:0] STEER_STOP  = 2'd1;
    localparam logic [1:0] STEER_LEFT  = 2'd2;
    localparam logic [1:0] STEER_RIGHT = 2'd3;

    // round end conditions
    localparam logic [2:0] ROUND_VALID    = 3'd5;
    localparam logic [3:0] ROUND_ATTEMPTS = 4'd11;

    // reciprocals for exact 32-bit division by 3 and by 10
    localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

    // reset values of the registers
    localparam logic [15:0] RST_VALID_RANGE   = 16'd3000;
    localparam logic [15:0] RST_STOP_DISTANCE = 16'd500;
    localparam logic [15:0] RST_STEER_MARGIN  = 16'd50;
    localparam logic [16:0] RST_ALARM_SUM     = 17'd2000;

    typedef struct packed {
        logic        sensor;
        logic [15:0] echo_ticks;
    } t_in_item;

    typedef struct packed {
        logic [20:0] distance_a;
        logic [20:0] distance_b;
        logic [1:0]  steer;
        logic        alarm;
    } t_out_item;

    typedef struct packed {
        logic [15:0] valid_range;
        logic [15:0] stop_distance;
        logic [15:0] steer_margin;
        logic [16:0] alarm_sum;
    } t_cfg;

    // one finished round: trimmed sum before the divide, or the last raw sample
    typedef struct packed {
        logic        phase;
        logic        success;
        logic [31:0] value;
    } t_round_rec;

    // floor(13 * r / 10) for a remainder r of 0 to 9
    function automatic logic [3:0] frac13(input logic [3:0] r);
        logic [3:0] v;
        unique case (r)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd1;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd3;
            4'd4:    v = 4'd5;
            4'd5:    v = 4'd6;
            4'd6:    v = 4'd7;
            4'd7:    v = 4'd9;
            4'd8:    v = 4'd10;
            4'd9:    v = 4'd11;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/dsts_front.sv]
// front end: sample accumulation of the sonar rounds, one sample per cycle while the round queue is not full
// depends on dsts_pkg and the assertion macro header
module dsts_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  dsts_pkg::t_in_item    i_in_data,
    input  logic [15:0]           i_valid_range,
    input  logic                  i_queue_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output dsts_pkg::t_round_rec  o_rec
);

    logic        r_phase;
    logic [2:0]  r_valid_count;
    logic [3:0]  r_attempt_count;
    logic [17:0] r_valid_sum;
    logic [15:0] r_largest;
    logic [15:0] r_smallest;
    logic [20:0] r_last_raw;

    logic        n_phase;
    logic [2:0]  n_valid_count;
    logic [3:0]  n_attempt_count;
    logic [17:0] n_valid_sum;
    logic [15:0] n_largest;
    logic [15:0] n_smallest;
    logic [20:0] n_last_raw;

    logic        w_take;
    logic [20:0] w_dist;
    logic [31:0] w_diff;
    logic        w_push;
    logic        w_success;

    assign o_in_stall = i_queue_full;
    assign w_take     = i_in_valid && !i_queue_full && (i_in_data.sensor == r_phase);
    // ticks * 17
    assign w_dist     = {i_in_data.echo_ticks, 4'b0} + {5'b0, i_in_data.echo_ticks};

    always_comb begin
        n_phase         = r_phase;
        n_valid_count   = r_valid_count;
        n_attempt_count = r_attempt_count;
        n_valid_sum     = r_valid_sum;
        n_largest       = r_largest;
        n_smallest      = r_smallest;
        n_last_raw      = r_last_raw;
        w_push          = 1'b0;
        w_success       = 1'b0;
        w_diff          = '0;
        if (w_take) begin
            n_last_raw = w_dist;
            if (w_dist != '0) begin
                n_attempt_count = r_attempt_count + 4'd1;
                if (w_dist <= {5'b0, i_valid_range}) begin
                    n_valid_count = r_valid_count + 3'd1;
                    n_valid_sum   = r_valid_sum + w_dist[17:0];
                    if (w_dist[15:0] > r_largest) begin
                        n_largest = w_dist[15:0];
                    end
                    if (w_dist[15:0] < r_smallest) begin
                        n_smallest = w_dist[15:0];
                    end
                end
                if (n_valid_count == dsts_pkg::ROUND_VALID) begin
                    w_push    = 1'b1;
                    w_success = 1'b1;
                end else if (n_attempt_count >= dsts_pkg::ROUND_ATTEMPTS) begin
                    w_push = 1'b1;
                end
            end
        end
        // wraps to a large unsigned value when the masked sum is small
        w_diff = {14'b0, n_valid_sum} - {16'b0, n_largest} - {16'b0, n_smallest};
        if (w_push) begin
            n_phase         = ~r_phase;
            n_valid_count   = '0;
            n_attempt_count = '0;
            n_valid_sum     = '0;
            n_largest       = '0;
            n_smallest      = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= 1'b0;
            r_valid_count   <= '0;
            r_attempt_count <= '0;
            r_valid_sum     <= '0;
            r_largest       <= '0;
            r_smallest      <= '1;
            r_last_raw      <= '0;
        end else begin
            r_phase         <= n_phase;
            r_valid_count   <= n_valid_count;
            r_attempt_count <= n_attempt_count;
            r_valid_sum     <= n_valid_sum;
            r_largest       <= n_largest;
            r_smallest      <= n_smallest;
            r_last_raw      <= n_last_raw;
        end
    end

    assign o_push          = w_push;
    assign o_rec.phase     = r_phase;
    assign o_rec.success   = w_success;
    assign o_rec.value     = w_success ? w_diff : {11'b0, n_last_raw};

    `include "dual_sonar_trimmed_mean_steer_assert.svh"

    `DSTS_ASSERT_ALWAYS(a_valid_count_bound, r_valid_count < dsts_pkg::ROUND_VALID, "valid count ran past round end")
    `DSTS_ASSERT_ALWAYS(a_attempt_bound, r_attempt_count < dsts_pkg::ROUND_ATTEMPTS, "attempt count ran past round end")
    `DSTS_ASSERT_NEXT(a_round_cleared, o_push, r_valid_count == '0 && r_attempt_count == '0 && r_phase != $past(r_phase), "round not restarted after end")

endmodule

[rtl/dsts_fifo.sv]
// short queue of finished rounds between front and back
// depends on dsts_pkg and the assertion macro header
module dsts_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dsts_pkg::t_round_rec  i_data,
    input  logic                  i_pop,
    output dsts_pkg::t_round_rec  o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    dsts_pkg::t_round_rec r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `include "dual_sonar_trimmed_mean_steer_assert.svh"

    `DSTS_ASSERT_IMPL(a_no_overflow, i_push, !o_full, "round record pushed into full queue")
    `DSTS_ASSERT_IMPL(a_no_underflow, i_pop, !o_empty, "pop from empty queue")
    `DSTS_ASSERT_NEXT(a_count_step, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "queue count lost a record")

endmodule

[rtl/dsts_back.sv]
// back end: trimmed mean divide, b scaling, steering and alarm, output register
// depends on dsts_pkg
module dsts_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rec_valid,
    input  dsts_pkg::t_round_rec  i_rec,
    input  dsts_pkg::t_cfg        i_cfg,
    input  logic                  i_out_stall,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output dsts_pkg::t_out_item   o_out_data
);

    // stage 1: round value after the divide by 3, or the raw sample of a failed round
    logic        r_v1;
    logic        r_ph1;
    logic        r_succ1;
    logic [31:0] r_q1;
    // held result of the a round
    logic [20:0] r_held;
    logic        r_a_ok;
    // stage 2: b value and its tenth
    logic        r_v2;
    logic [31:0] r_q2;
    logic [28:0] r_a2;
    logic [20:0] r_da2;
    logic        r_alarm_en2;
    // stage 3: scaled b and alarm
    logic        r_v3;
    logic [31:0] r_db3;
    logic [20:0] r_da3;
    logic        r_alarm3;
    // output register
    logic                 r_ov;
    dsts_pkg::t_out_item  r_out;

    logic [63:0] w_prod3;
    logic [63:0] w_prod10;
    logic [31:0] w_q1_n;
    logic [3:0]  w_rem;
    logic [31:0] w_db;
    logic [32:0] w_sum_ab;
    logic [32:0] w_db_m;
    logic [32:0] w_da_m;
    logic [1:0]  w_steer;

    logic w_rdy_out, w_mv3, w_rdy3, w_mv2, w_rdy2, w_mv1, w_rdy1, w_pop;

    assign w_rdy_out = !r_ov || !i_out_stall;
    assign w_mv3     = r_v3 && w_rdy_out;
    assign w_rdy3    = !r_v3 || w_rdy_out;
    assign w_mv2     = r_v2 && w_rdy3;
    assign w_rdy2    = !r_v2 || w_rdy3;
    // an a round record is absorbed into the held registers and never waits
    assign w_mv1     = r_v1 && (!r_ph1 || w_rdy2);
    assign w_rdy1    = !r_v1 || w_mv1;
    assign w_pop     = i_rec_valid && w_rdy1;
    assign o_pop     = w_pop;

    assign w_prod3  = {32'b0, i_rec.value} * {32'b0, dsts_pkg::RECIP_3};
    assign w_q1_n   = i_rec.success ? {1'b0, w_prod3[63:33]} : i_rec.value;
    assign w_prod10 = {32'b0, r_q1} * {32'b0, dsts_pkg::RECIP_10};

    // q - 10a modulo 16, then 13a + floor(13 r / 10)
    assign w_rem    = r_q2[3:0] - {r_a2[2:0], 1'b0} - {r_a2[0], 3'b0};
    assign w_db     = {r_a2, 3'b0} + {1'b0, r_a2, 2'b0} + {3'b0, r_a2}
                      + {28'b0, dsts_pkg::frac13(w_rem)};
    assign w_sum_ab = {12'b0, r_da2} + {1'b0, r_q2};

    assign w_db_m   = {1'b0, r_db3} + {17'b0, i_cfg.steer_margin};
    assign w_da_m   = {12'b0, r_da3} + {17'b0, i_cfg.steer_margin};

    always_comb begin
        if (r_da3 < {5'b0, i_cfg.stop_distance} || r_db3 < {16'b0, i_cfg.stop_distance}) begin
            w_steer = dsts_pkg::STEER_STOP;
        end else if ({12'b0, r_da3} > w_db_m) begin
            w_steer = dsts_pkg::STEER_LEFT;
        end else if ({1'b0, r_db3} > w_da_m) begin
            w_steer = dsts_pkg::STEER_RIGHT;
        end else begin
            w_steer = dsts_pkg::STEER_GO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_ov   <= 1'b0;
            r_a_ok <= 1'b0;
            r_held <= '0;
        end else begin
            if (w_pop) begin
                r_v1 <= 1'b1;
            end else if (w_mv1) begin
                r_v1 <= 1'b0;
            end
            if (w_mv1 && r_ph1) begin
                r_v2 <= 1'b1;
            end else if (w_mv2) begin
                r_v2 <= 1'b0;
            end
            if (w_mv2) begin
                r_v3 <= 1'b1;
            end else if (w_mv3) begin
                r_v3 <= 1'b0;
            end
            if (w_mv3) begin
                r_ov <= 1'b1;
            end else if (w_rdy_out) begin
                r_ov <= 1'b0;
            end
            if (w_mv1) begin
                if (!r_ph1) begin
                    r_held <= r_q1[20:0];
                    r_a_ok <= r_succ1;
                end else begin
                    r_a_ok <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_ph1   <= i_rec.phase;
            r_succ1 <= i_rec.success;
            r_q1    <= w_q1_n;
        end
        if (w_mv1 && r_ph1) begin
            r_q2        <= r_q1;
            r_a2        <= w_prod10[63:35];
            r_da2       <= r_held;
            r_alarm_en2 <= r_succ1 && r_a_ok;
        end
        if (w_mv2) begin
            r_db3    <= w_db;
            r_da3    <= r_da2;
            r_alarm3 <= r_alarm_en2 && (w_sum_ab > {16'b0, i_cfg.alarm_sum});
        end
        if (w_mv3) begin
            r_out.distance_a <= r_da3;
            r_out.distance_b <= r_db3[20:0];
            r_out.steer      <= w_steer;
            r_out.alarm      <= r_alarm3;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

[rtl/dual_sonar_trimmed_mean_steer.sv]
// dual sonar trimmed mean filter with steering decision
// top level: configuration registers, front end, round queue, back end
// depends on dsts_pkg, dsts_front, dsts_fifo, dsts_back
//
// input channel: one echo width per beat (sensor, echo_ticks) with valid and
//   stall. a beat is taken every cycle unless the round queue is full; beats
//   from the sensor whose round is not running are dropped.
// the front end gathers a round (5 valid samples or 11 nonzero tries) at one
//   beat per cycle unless the queue is full; each finished round goes to a QUEUE_DEPTH deep queue.
// the back end divides, scales sensor b by 13/10 and picks stop, left, right
//   or go plus the alarm bit; one output beat per finished b round.
// a finished b round passes the round queue, back stages 1 to 3 and the output register.
// throughput: one input beat per cycle while the queue is not full; the back end takes
//   one round record per cycle unless the output stalls, its two multiplies each owning a pipeline stage.
// output stall holds the result register; the back pipeline then fills, the
//   queue fills and the input channel stalls.
// reset (synchronous, active low) restarts at the sensor a round, empties the
//   queue and pipeline and loads the register defaults. writes on the config
//   port take effect at the next cycle.
module dual_sonar_trimmed_mean_steer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  dsts_pkg::t_in_item                i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output dsts_pkg::t_out_item               o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_addr,
    input  logic [dsts_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    dsts_pkg::t_cfg        r_cfg;
    dsts_pkg::t_round_rec  w_push_rec;
    dsts_pkg::t_round_rec  w_head_rec;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_empty;
    logic                  w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_range   <= dsts_pkg::RST_VALID_RANGE;
            r_cfg.stop_distance <= dsts_pkg::RST_STOP_DISTANCE;
            r_cfg.steer_margin  <= dsts_pkg::RST_STEER_MARGIN;
            r_cfg.alarm_sum     <= dsts_pkg::RST_ALARM_SUM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dsts_pkg::CFG_VALID_RANGE:   r_cfg.valid_range   <= i_cfg_wdata[15:0];
                dsts_pkg::CFG_STOP_DISTANCE: r_cfg.stop_distance <= i_cfg_wdata[15:0];
                dsts_pkg::CFG_STEER_MARGIN:  r_cfg.steer_margin  <= i_cfg_wdata[15:0];
                dsts_pkg::CFG_ALARM_SUM:     r_cfg.alarm_sum     <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    dsts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_valid_range (r_cfg.valid_range),
        .i_queue_full  (w_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_rec         (w_push_rec)
    );

    dsts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_rec),
        .i_pop   (w_pop),
        .o_data  (w_head_rec),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    dsts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!w_empty),
        .i_rec       (w_head_rec),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[verif/dual_sonar_trimmed_mean_steer_test.sv]
// self-checking testbench for dual_sonar_trimmed_mean_steer
// predicts each steering result from the echo beats, compares at the output
// depends on dsts_pkg and the dual_sonar_trimmed_mean_steer rtl
module dual_sonar_trimmed_mean_steer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dsts_pkg::*;

    localparam logic SENSOR_A = 1'b0;
    localparam logic SENSOR_B = 1'b1;
    localparam logic [20:0] TENTHS_PER_TICK = 21'd17;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_addr = CFG_VALID_RANGE;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    dual_sonar_trimmed_mean_steer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow of the block: thresholds and round state
    t_cfg        cfg_now;
    logic        phase_b;
    logic [2:0]  n_valid;
    logic [3:0]  n_tries;
    logic [17:0] sum_valid;
    logic [15:0] max_d;
    logic [15:0] min_d;
    logic [20:0] last_d;
    logic [20:0] dist_a_held;
    logic        a_ok;

    t_out_item   due_steer[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    int          send_calm = 0;
    int          stall_left = 0;
    int          calm_left = 0;
    int          base_a = 1;
    int          base_b = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s: got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic void clear_round();
        n_valid = '0;
        n_tries = '0;
        sum_valid = '0;
        max_d = '0;
        min_d = '1;
    endfunction

    function automatic void reset_shadow();
        cfg_now.valid_range = RST_VALID_RANGE;
        cfg_now.stop_distance = RST_STOP_DISTANCE;
        cfg_now.steer_margin = RST_STEER_MARGIN;
        cfg_now.alarm_sum = RST_ALARM_SUM;
        phase_b = SENSOR_A;
        clear_round();
        last_d = '0;
        dist_a_held = '0;
        a_ok = 1'b0;
    endfunction

    // advance the shadow by one accepted beat, queue a result when a b round ends
    function automatic void track_echo(input t_in_item it);
        logic [20:0] d;
        logic        ok;
        logic [31:0] res;
        logic [63:0] scaled;
        longint      da;
        longint      db;
        t_out_item   o;
        if (it.sensor != phase_b)
            return;
        d = 21'(it.echo_ticks) * TENTHS_PER_TICK;
        last_d = d;
        if (d == '0)
            return;
        n_tries = n_tries + 4'd1;
        if (d <= 21'(cfg_now.valid_range)) begin
            n_valid = n_valid + 3'd1;
            sum_valid = sum_valid + 18'(d);
            if (d > 21'(max_d)) max_d = d[15:0];
            if (d < 21'(min_d)) min_d = d[15:0];
        end
        if (n_valid == ROUND_VALID)
            ok = 1'b1;
        else if (n_tries >= ROUND_ATTEMPTS)
            ok = 1'b0;
        else
            return;
        if (ok)
            res = (32'(sum_valid) - 32'(max_d) - 32'(min_d)) / 32'd3;
        else
            res = 32'(last_d);
        clear_round();
        if (phase_b == SENSOR_A) begin
            dist_a_held = res[20:0];
            a_ok = ok;
            phase_b = SENSOR_B;
            return;
        end
        scaled = (64'(res) * 64'd13) / 64'd10;
        da = longint'(dist_a_held);
        db = longint'(scaled);
        o.distance_a = dist_a_held;
        o.distance_b = scaled[20:0];
        o.alarm = ok && a_ok && (64'(dist_a_held) + 64'(res) > 64'(cfg_now.alarm_sum));
        if (da < longint'(cfg_now.stop_distance) || db < longint'(cfg_now.stop_distance))
            o.steer = STEER_STOP;
        else if (da - db > longint'(cfg_now.steer_margin))
            o.steer = STEER_LEFT;
        else if (db - da > longint'(cfg_now.steer_margin))
            o.steer = STEER_RIGHT;
        else
            o.steer = STEER_GO;
        due_steer.push_back(o);
        a_ok = 1'b0;
        phase_b = SENSOR_A;
    endfunction

    // receiver stalls: short bursts, with calm stretches in between
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= (stall_left > 0);
        end else if (calm_left > 0) begin
            calm_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 40) == 0) calm_left = $urandom_range(20, 80);
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_steer.size() == 0) begin
                report_mismatch("result beat with none expected", o_out_data, 0);
            end else begin
                want = due_steer.pop_front();
                if (o_out_data.distance_a !== want.distance_a)
                    report_mismatch("distance_a", o_out_data.distance_a, want.distance_a);
                if (o_out_data.distance_b !== want.distance_b)
                    report_mismatch("distance_b", o_out_data.distance_b, want.distance_b);
                if (o_out_data.steer !== want.steer)
                    report_mismatch("steer", o_out_data.steer, want.steer);
                if (o_out_data.alarm !== want.alarm)
                    report_mismatch("alarm", o_out_data.alarm, want.alarm);
            end
        end
    end

    task automatic send_echo(input logic sensor, input logic [15:0] ticks);
        t_in_item it;
        it.sensor = sensor;
        it.echo_ticks = ticks;
        if (idle_on && send_calm == 0 && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 30) == 0)
            send_calm = $urandom_range(10, 40);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_echo(it);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // drain the block, then rewrite all four thresholds
    task automatic load_thresholds(input t_cfg c);
        i_in_valid <= 1'b0;
        while (due_steer.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        // the top data bit is junk for the 16-bit registers
        put_reg(CFG_VALID_RANGE, {1'($urandom), c.valid_range});
        put_reg(CFG_STOP_DISTANCE, {1'($urandom), c.stop_distance});
        put_reg(CFG_STEER_MARGIN, {1'($urandom), c.steer_margin});
        put_reg(CFG_ALARM_SUM, c.alarm_sum);
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    function automatic logic [15:0] pick_ticks();
        int top;
        int r;
        int j;
        int v;
        top = cfg_now.valid_range / 17;
        r = $urandom_range(0, 99);
        if (r < 7) begin
            v = 0;
        end else if (r < 14) begin
            v = $urandom_range(0, 65535);
        end else if (r < 22 || top == 0) begin
            v = top + 1 + $urandom_range(0, 30);
        end else begin
            j = $urandom_range(0, 1) ? 2 : top / 6 + 1;
            v = (phase_b ? base_b : base_a) + $urandom_range(0, 2 * j) - j;
            if (v < 1) v = 1;
            if (v > top) v = top;
        end
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    task automatic run_random(input int n_items);
        int          done;
        int          top;
        logic        s;
        logic [15:0] t;
        done = 0;
        while (done < n_items) begin
            top = cfg_now.valid_range / 17;
            if (top < 1) top = 1;
            // fresh round: pick where its samples cluster, b often near a/1.3
            if (n_tries == '0 && n_valid == '0) begin
                if (phase_b == SENSOR_A)
                    base_a = $urandom_range(1, top);
                else if ($urandom_range(0, 1))
                    base_b = (base_a * 10 / 13 < 1) ? 1 : base_a * 10 / 13;
                else
                    base_b = $urandom_range(1, top);
            end
            if ($urandom_range(0, 9) == 0) begin
                s = ~phase_b;
                t = 16'($urandom);
            end else begin
                s = phase_b;
                t = pick_ticks();
                done++;
            end
            send_echo(s, t);
        end
    endtask

    function automatic t_cfg random_thresholds();
        t_cfg c;
        int   vr;
        vr = $urandom_range(17 * 20, 65535);
        c.valid_range = 16'(vr);
        c.stop_distance = 16'($urandom_range(0, vr));
        c.steer_margin = 16'($urandom_range(0, vr / 4));
        c.alarm_sum = 17'($urandom_range(0, 2 * vr));
        return c;
    endfunction

    // default thresholds: a round ending on both conditions, a failed round
    task automatic test_directed_defaults();
        int unsigned a_ticks[13] = '{0, 177, 65535, 200, 1000, 300, 177,
                                     100, 50, 176, 1, 90, 0};
        int unsigned b_ticks[11] = '{30, 40, 500, 177, 1024, 32768, 2048, 4096,
                                     16384, 8192, 65535};
        t_cfg c;
        c.valid_range = RST_VALID_RANGE;
        c.stop_distance = RST_STOP_DISTANCE;
        c.steer_margin = RST_STEER_MARGIN;
        c.alarm_sum = RST_ALARM_SUM;
        load_thresholds(c);
        send_echo(SENSOR_B, 16'd100);
        foreach (a_ticks[k]) begin
            if (k < 12) send_echo(SENSOR_A, 16'(a_ticks[k]));
        end
        send_echo(SENSOR_A, 16'd60);
        foreach (b_ticks[k]) send_echo(SENSOR_B, 16'(b_ticks[k]));
    endtask

    // widest range: five top samples overflow the running sum
    task automatic test_directed_sum_wrap();
        t_cfg c;
        c.valid_range = 16'hFFFF;
        c.stop_distance = '0;
        c.steer_margin = '0;
        c.alarm_sum = '0;
        load_thresholds(c);
        repeat (5) send_echo(SENSOR_A, 16'd3855);
        for (int k = 1; k <= 5; k++) send_echo(SENSOR_B, 16'(k));
    endtask

    task automatic test_random_defaults();
        t_cfg c;
        c.valid_range = RST_VALID_RANGE;
        c.stop_distance = RST_STOP_DISTANCE;
        c.steer_margin = RST_STEER_MARGIN;
        c.alarm_sum = RST_ALARM_SUM;
        load_thresholds(c);
        run_random(250);
    endtask

    task automatic test_random_wide_open();
        t_cfg c;
        c.valid_range = 16'hFFFF;
        c.stop_distance = '0;
        c.steer_margin = '0;
        c.alarm_sum = 17'h1FFFF;
        load_thresholds(c);
        run_random(250);
    endtask

    // nothing is ever in range, every round fails on its attempts
    task automatic test_random_blind();
        t_cfg c;
        c.valid_range = '0;
        c.stop_distance = 16'hFFFF;
        c.steer_margin = 16'hFFFF;
        c.alarm_sum = '0;
        load_thresholds(c);
        run_random(150);
    endtask

    task automatic test_random_mixed();
        t_cfg c;
        c.valid_range = 16'($urandom);
        c.stop_distance = 16'($urandom);
        c.steer_margin = 16'($urandom);
        c.alarm_sum = 17'($urandom);
        load_thresholds(c);
        run_random(150);
        repeat (3) begin
            load_thresholds(random_thresholds());
            run_random(150);
        end
    endtask

    task automatic test_random_back_to_back();
        load_thresholds(random_thresholds());
        idle_on = 1'b0;
        send_calm = 0;
        run_random(300);
    endtask

    initial begin
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_directed_sum_wrap();
        test_random_defaults();
        test_random_wide_open();
        test_random_blind();
        test_random_mixed();
        test_random_back_to_back();
        i_in_valid <= 1'b0;
        for (int w = 0; w < 5000 && due_steer.size() > 0; w++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (due_steer.size() != 0)
            report_mismatch("results never delivered", 0, due_steer.size());
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
